/* rtl/xoshiro256ss_ranged_rng_core_macros.svh */
// assertion macros for the ranged xoshiro256** generator core
// expects clk and rst_n in the scope where the macros are used
`ifndef XOSHIRO256SS_RANGED_RNG_CORE_MACROS_SVH
`define XOSHIRO256SS_RANGED_RNG_CORE_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define XRR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define XRR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/xrr_pkg.sv */
// shared constants, command/status types and helpers of the rng core
// no dependencies
`default_nettype none

package xrr_pkg;

    localparam int WORD_W    = 64;
    localparam int HALF_W    = WORD_W / 2;
    localparam int NUM_WORDS = 4;
    localparam int IDX_W     = $clog2(NUM_WORDS);

    // generator words after reset
    localparam logic [WORD_W-1:0] RNG_INIT0 = 64'h853c49e6748fea9b;
    localparam logic [WORD_W-1:0] RNG_INIT1 = 64'hda3e39cb94b95bdb;
    localparam logic [WORD_W-1:0] RNG_INIT2 = 64'h647c4677a2884327;
    localparam logic [WORD_W-1:0] RNG_INIT3 = 64'hc3f5015f73e1f6f4;

    // splitmix64 constants
    localparam logic [WORD_W-1:0] SM_GAMMA = 64'h9e3779b97f4a7c15;
    localparam logic [WORD_W-1:0] SM_MUL1  = 64'hbf58476d1ce4e5b9;
    localparam logic [WORD_W-1:0] SM_MUL2  = 64'h94d049bb133111eb;

    // xoshiro256** constants
    localparam int XS_SHIFT   = 17;
    localparam int XS_ROT     = 45;
    localparam int SS_ROT     = 7;
    localparam int FRAC_SHIFT = 11;

    // remainder divider: one quotient bit per cycle
    localparam int DIV_STEPS = WORD_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    // low-half multiplier: three 32x32 partial products plus drain
    localparam int MUL_CNT_W = 3;
    localparam logic [MUL_CNT_W-1:0] MUL_FIRST = 3'd1;
    localparam logic [MUL_CNT_W-1:0] MUL_HI_B  = 3'd2;
    localparam logic [MUL_CNT_W-1:0] MUL_LAST  = 3'd4;

    localparam logic [IDX_W-1:0] SEED_LAST = IDX_W'(NUM_WORDS - 1);

    typedef enum logic [1:0] {
        ACT_SEED = 2'd0,
        ACT_INT  = 2'd1,
        ACT_FRAC = 2'd2,
        ACT_NONE = 2'd3
    } action_t;

    typedef enum logic {
        MUL_SEL_1 = 1'b0,
        MUL_SEL_2 = 1'b1
    } mul_sel_t;

    typedef enum logic {
        DIV_LIMIT = 1'b0,
        DIV_REM   = 1'b1
    } div_sel_t;

    // controller to datapath
    typedef struct packed {
        logic     load;
        logic     seed_step;
        logic     mul_start;
        mul_sel_t mul_sel;
        logic     z_mix;
        logic     seed_store;
        logic     div_start;
        div_sel_t div_sel;
        logic     limit_load;
        logic     draw;
        logic     out_load;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        action_t action;
        logic    bad_bound;
        logic    idx_last;
        logic    mul_busy;
        logic    div_busy;
        logic    below_limit;
        logic    out_free;
    } status_t;

    function automatic logic [WORD_W-1:0] rotl64(input logic [WORD_W-1:0] v, input int k);
        return (v << k) | (v >> (WORD_W - k));
    endfunction

endpackage

`default_nettype wire

/* rtl/xrr_if.sv */
// request and response channel interfaces of the rng core
// no dependencies
`default_nettype none

interface xrr_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [63:0] operand;

    modport source (output valid, output action, output operand, input ready);
    modport sink   (input valid, input action, input operand, output ready);
endinterface

interface xrr_rsp_if;
    logic        valid;
    logic        ready;
    logic [63:0] value;
    logic        error;

    modport source (output valid, output value, output error, input ready);
    modport sink   (input valid, input value, input error, output ready);
endinterface

`default_nettype wire

/* rtl/xrr_div.sv */
// 64-bit restoring remainder unit, one quotient bit per cycle
// depends on xrr_pkg
`default_nettype none

module xrr_div import xrr_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [WORD_W-1:0] dividend,
    input  wire logic [WORD_W-1:0] divisor,
    output logic                   busy,
    output logic [WORD_W-1:0]      rem
);

    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [WORD_W-1:0]    rem_reg;
    logic [WORD_W-1:0]    dvd_reg;
    logic [WORD_W-1:0]    dsr_reg;
    logic [WORD_W:0]      shifted;
    logic [WORD_W:0]      diff;
    logic [WORD_W-1:0]    rem_next;

    // shift in the next dividend bit, subtract when it fits
    always_comb
    begin
        shifted  = {rem_reg, dvd_reg[WORD_W-1]};
        diff     = shifted - {1'b0, dsr_reg};
        rem_next = diff[WORD_W] ? shifted[WORD_W-1:0] : diff[WORD_W-1:0];
    end

    // step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= DIV_CNT_W'(DIV_STEPS);
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // operand and partial remainder
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            dvd_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= rem_next;
            dvd_reg <= dvd_reg << 1;
        end
    end

    assign busy = (cnt_reg != '0);
    assign rem  = rem_reg;

endmodule

`default_nettype wire

/* rtl/xrr_datapath.sv */
// generator state, splitmix multiplier, draw logic and result register
// depends on xrr_pkg and xrr_div
`default_nettype none

module xrr_datapath import xrr_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cmd_t              cmd,
    output status_t                status,
    input  wire logic [1:0]        req_action,
    input  wire logic [WORD_W-1:0] req_operand,
    output logic                   rsp_valid,
    input  wire logic              rsp_ready,
    output logic [WORD_W-1:0]      rsp_value,
    output logic                   rsp_error
);

    action_t              action_reg;
    logic [WORD_W-1:0]    operand_reg;
    logic [WORD_W-1:0]    acc_reg;
    logic [WORD_W-1:0]    z_reg;
    logic [WORD_W-1:0]    word_reg [NUM_WORDS];
    logic [IDX_W-1:0]     idx_reg;
    logic [WORD_W-1:0]    limit_reg;
    logic [WORD_W-1:0]    draw_reg;
    logic [MUL_CNT_W-1:0] mul_cnt_reg;
    mul_sel_t             mul_sel_reg;
    logic [WORD_W-1:0]    prod_reg;
    logic [WORD_W-1:0]    macc_reg;
    logic                 rsp_valid_reg;
    logic [WORD_W-1:0]    value_reg;
    logic                 error_reg;

    logic [WORD_W-1:0]    acc_sum;
    logic [WORD_W-1:0]    mul_b;
    logic [HALF_W-1:0]    mul_x;
    logic [HALF_W-1:0]    mul_y;
    logic [WORD_W-1:0]    prod_next;
    logic [WORD_W-1:0]    t2;
    logic [WORD_W-1:0]    t3;
    logic [WORD_W-1:0]    m5;
    logic [WORD_W-1:0]    m5_rot;
    logic [WORD_W-1:0]    draw_next;
    logic [WORD_W-1:0]    div_dvd;
    logic                 div_busy;
    logic [WORD_W-1:0]    div_rem;
    logic                 bad_bound;
    logic                 out_free;
    logic [WORD_W-1:0]    out_value;

    assign bad_bound = (operand_reg == '0) || operand_reg[WORD_W-1];
    assign out_free  = !rsp_valid_reg || rsp_ready;

    // request capture
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            action_reg  <= action_t'(req_action);
            operand_reg <= req_operand;
        end
    end

    // splitmix64 accumulator and mix word
    assign acc_sum = acc_reg + SM_GAMMA;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            acc_reg <= req_operand;
        end
        else if (cmd.seed_step)
        begin
            acc_reg <= acc_sum;
        end

        if (cmd.seed_step)
        begin
            z_reg <= acc_sum ^ (acc_sum >> 30);
        end
        else if (cmd.z_mix)
        begin
            z_reg <= macc_reg ^ (macc_reg >> 27);
        end
    end

    // low 64 bits of z times constant from three 32x32 partial products
    always_comb
    begin
        mul_b = (mul_sel_reg == MUL_SEL_1) ? SM_MUL1 : SM_MUL2;
        case (mul_cnt_reg)
            MUL_FIRST:
            begin
                mul_x = z_reg[HALF_W-1:0];
                mul_y = mul_b[HALF_W-1:0];
            end
            MUL_HI_B:
            begin
                mul_x = z_reg[HALF_W-1:0];
                mul_y = mul_b[WORD_W-1:HALF_W];
            end
            default:
            begin
                mul_x = z_reg[WORD_W-1:HALF_W];
                mul_y = mul_b[HALF_W-1:0];
            end
        endcase
        prod_next = {{HALF_W{1'b0}}, mul_x} * {{HALF_W{1'b0}}, mul_y};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_cnt_reg <= '0;
        end
        else if (cmd.mul_start)
        begin
            mul_cnt_reg <= MUL_FIRST;
        end
        else if (mul_cnt_reg == MUL_LAST)
        begin
            mul_cnt_reg <= '0;
        end
        else if (mul_cnt_reg != '0)
        begin
            mul_cnt_reg <= mul_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_start)
        begin
            mul_sel_reg <= cmd.mul_sel;
        end
        if (mul_cnt_reg != '0)
        begin
            prod_reg <= prod_next;
            if (mul_cnt_reg == MUL_HI_B)
            begin
                macc_reg <= prod_reg;
            end
            else if (mul_cnt_reg != MUL_FIRST)
            begin
                macc_reg <= macc_reg + {prod_reg[HALF_W-1:0], {HALF_W{1'b0}}};
            end
        end
    end

    // xoshiro256** output word
    always_comb
    begin
        t2        = word_reg[2] ^ word_reg[0];
        t3        = word_reg[3] ^ word_reg[1];
        m5        = word_reg[1] + (word_reg[1] << 2);
        m5_rot    = rotl64(m5, SS_ROT);
        draw_next = m5_rot + (m5_rot << 3);
    end

    // generator words: state advance on a draw, splitmix fill on seed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_reg[0] <= RNG_INIT0;
            word_reg[1] <= RNG_INIT1;
            word_reg[2] <= RNG_INIT2;
            word_reg[3] <= RNG_INIT3;
            idx_reg     <= '0;
        end
        else
        begin
            if (cmd.draw)
            begin
                word_reg[0] <= word_reg[0] ^ t3;
                word_reg[1] <= word_reg[1] ^ t2;
                word_reg[2] <= t2 ^ (word_reg[1] << XS_SHIFT);
                word_reg[3] <= rotl64(t3, XS_ROT);
            end
            else if (cmd.seed_store)
            begin
                word_reg[idx_reg] <= macc_reg ^ (macc_reg >> 31);
            end

            if (cmd.load)
            begin
                idx_reg <= '0;
            end
            else if (cmd.seed_store)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.draw)
        begin
            draw_reg <= draw_next;
        end
        if (cmd.limit_load)
        begin
            limit_reg <= div_rem;
        end
    end

    // remainder unit: threshold (2^64 - n) mod n, then draw mod n
    assign div_dvd = (cmd.div_sel == DIV_LIMIT) ? ('0 - operand_reg) : draw_reg;

    xrr_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dvd),
        .divisor  (operand_reg),
        .busy     (div_busy),
        .rem      (div_rem)
    );

    // result selection
    always_comb
    begin
        case (action_reg)
            ACT_SEED: out_value = operand_reg;
            ACT_INT:  out_value = bad_bound ? '0 : div_rem;
            ACT_FRAC: out_value = draw_reg >> FRAC_SHIFT;
            default:  out_value = '0;
        endcase
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            value_reg <= out_value;
            error_reg <= (action_reg == ACT_INT) && bad_bound;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_value = value_reg;
    assign rsp_error = error_reg;

    // status back to the controller
    always_comb
    begin
        status             = '0;
        status.action      = action_reg;
        status.bad_bound   = bad_bound;
        status.idx_last    = (idx_reg == SEED_LAST);
        status.mul_busy    = (mul_cnt_reg != '0);
        status.div_busy    = div_busy;
        status.below_limit = (draw_reg < limit_reg);
        status.out_free    = out_free;
    end

endmodule

`default_nettype wire

/* rtl/xrr_ctrl.sv */
// sequencing state machine of the rng core
// depends on xrr_pkg
`default_nettype none

module xrr_ctrl import xrr_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    req_valid,
    output logic         req_ready,
    input  wire status_t status,
    output cmd_t         cmd
);

    typedef enum logic [13:0] {
        S_IDLE       = 14'b00000000000001,
        S_DISPATCH   = 14'b00000000000010,
        S_SEED_ADD   = 14'b00000000000100,
        S_SEED_M1    = 14'b00000000001000,
        S_SEED_W1    = 14'b00000000010000,
        S_SEED_M2    = 14'b00000000100000,
        S_SEED_W2    = 14'b00000001000000,
        S_LIMIT      = 14'b00000010000000,
        S_LIMIT_WAIT = 14'b00000100000000,
        S_DRAW_INT   = 14'b00001000000000,
        S_CHECK      = 14'b00010000000000,
        S_REM_WAIT   = 14'b00100000000000,
        S_DRAW_FRAC  = 14'b01000000000000,
        S_FINISH     = 14'b10000000000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and datapath commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (status.action)
                    ACT_SEED: state_next = S_SEED_ADD;
                    ACT_INT:
                    begin
                        if (status.bad_bound)
                        begin
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            state_next = S_LIMIT;
                        end
                    end
                    ACT_FRAC: state_next = S_DRAW_FRAC;
                    default:  state_next = S_FINISH;
                endcase
            end
            S_SEED_ADD:
            begin
                cmd.seed_step = 1'b1;
                state_next    = S_SEED_M1;
            end
            S_SEED_M1:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = MUL_SEL_1;
                state_next    = S_SEED_W1;
            end
            S_SEED_W1:
            begin
                if (!status.mul_busy)
                begin
                    cmd.z_mix  = 1'b1;
                    state_next = S_SEED_M2;
                end
            end
            S_SEED_M2:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = MUL_SEL_2;
                state_next    = S_SEED_W2;
            end
            S_SEED_W2:
            begin
                if (!status.mul_busy)
                begin
                    cmd.seed_store = 1'b1;
                    state_next     = status.idx_last ? S_FINISH : S_SEED_ADD;
                end
            end
            S_LIMIT:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_LIMIT;
                state_next    = S_LIMIT_WAIT;
            end
            S_LIMIT_WAIT:
            begin
                if (!status.div_busy)
                begin
                    cmd.limit_load = 1'b1;
                    state_next     = S_DRAW_INT;
                end
            end
            S_DRAW_INT:
            begin
                cmd.draw   = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                // redraw while the word falls below the threshold
                if (status.below_limit)
                begin
                    state_next = S_DRAW_INT;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_REM;
                    state_next    = S_REM_WAIT;
                end
            end
            S_REM_WAIT:
            begin
                if (!status.div_busy)
                begin
                    state_next = S_FINISH;
                end
            end
            S_DRAW_FRAC:
            begin
                cmd.draw   = 1'b1;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/xoshiro256ss_ranged_rng_core.sv */
// Ranged xoshiro256** generator core: one request item at a time, one result item each.
// Seed work is bound by the multiplier, two products per state word; a fraction takes one draw;
// an integer runs two bit-serial remainders plus a redraw per rejected draw; a bad bound skips them.
// Throughput: next item accepted once the previous one has reached the output register.
// Reset: generator words take their fixed initial constants at once; no clearing pass.
// Depends on xrr_pkg, xrr_if, xrr_ctrl, xrr_datapath and the assertion macro header.
`default_nettype none
`include "xoshiro256ss_ranged_rng_core_macros.svh"

module xoshiro256ss_ranged_rng_core import xrr_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    xrr_req_if.sink   req,
    xrr_rsp_if.source rsp
);

    cmd_t    cmd;
    status_t status;

    // sequencer
    xrr_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // state, arithmetic and result register
    xrr_datapath u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .req_action  (req.action),
        .req_operand (req.operand),
        .rsp_valid   (rsp.valid),
        .rsp_ready   (rsp.ready),
        .rsp_value   (rsp.value),
        .rsp_error   (rsp.error)
    );

    // checks on the controller and datapath handoff
    `XRR_ASSERT_NOW(a_mul_start_idle, cmd.mul_start, !status.mul_busy, "multiplier restarted while busy")
    `XRR_ASSERT_NOW(a_div_start_idle, cmd.div_start, !status.div_busy, "divider restarted while busy")
    `XRR_ASSERT_NOW(a_out_load_free, cmd.out_load, status.out_free, "result overwrote a pending item")
    `XRR_ASSERT_NEXT(a_rsp_drain, rsp.valid && rsp.ready && !cmd.out_load, !rsp.valid, "taken item repeated")

endmodule

`default_nettype wire

/* tb/xoshiro256ss_ranged_rng_core_checker.sv */
// checker for the ranged xoshiro256** core: watches both channels, predicts every result item
// depends on xrr_pkg and the channel interfaces in xrr_if
`default_nettype none

module xoshiro256ss_ranged_rng_core_checker import xrr_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    xrr_req_if        req,
    xrr_rsp_if        rsp,
    output int        fail_count,
    output int        pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [WORD_W-1:0] value;
        logic              error;
    } rng_result_t;

    // own copy of the generator state
    logic [WORD_W-1:0] gen_words [NUM_WORDS];
    rng_result_t       expected_results [$];
    int                mismatches;

    function automatic logic [WORD_W-1:0] rotate_left(input logic [WORD_W-1:0] v,
                                                      input int unsigned k);
        if (k == 0)
        begin
            return v;
        end
        return (v << k) | (v >> (WORD_W - k));
    endfunction

    // one xoshiro256** output word, advancing the state
    function automatic logic [WORD_W-1:0] next_draw();
        logic [WORD_W-1:0] word_out;
        logic [WORD_W-1:0] shifted;
        word_out     = rotate_left(gen_words[1] * 64'd5, SS_ROT) * 64'd9;
        shifted      = gen_words[1] << XS_SHIFT;
        gen_words[2] = gen_words[2] ^ gen_words[0];
        gen_words[3] = gen_words[3] ^ gen_words[1];
        gen_words[1] = gen_words[1] ^ gen_words[2];
        gen_words[0] = gen_words[0] ^ gen_words[3];
        gen_words[2] = gen_words[2] ^ shifted;
        gen_words[3] = rotate_left(gen_words[3], XS_ROT);
        return word_out;
    endfunction

    // expected result item for one request item
    function automatic rng_result_t predict_rng_result(input action_t act,
                                                       input logic [WORD_W-1:0] opd);
        rng_result_t       res;
        logic [WORD_W-1:0] acc;
        logic [WORD_W-1:0] z;
        logic [WORD_W-1:0] limit;
        logic [WORD_W-1:0] r;
        res = '0;
        case (act)
            ACT_SEED:
            begin
                // splitmix64 expansion into the four words
                acc = opd;
                for (int i = 0; i < NUM_WORDS; i++)
                begin
                    acc          = acc + SM_GAMMA;
                    z            = acc;
                    z            = (z ^ (z >> 30)) * SM_MUL1;
                    z            = (z ^ (z >> 27)) * SM_MUL2;
                    gen_words[i] = z ^ (z >> 31);
                end
                res.value = opd;
            end
            ACT_INT:
            begin
                if (opd == '0 || opd[WORD_W-1])
                begin
                    res.error = 1'b1;
                end
                else
                begin
                    // reject draws below (2^64 - n) mod n
                    limit = (64'd0 - opd) % opd;
                    do
                    begin
                        r = next_draw();
                    end
                    while (r < limit);
                    res.value = r % opd;
                end
            end
            ACT_FRAC:
            begin
                res.value = next_draw() >> FRAC_SHIFT;
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    // compare accepted result items, then predict accepted request items
    always @(posedge clk or negedge rst_n)
    begin
        rng_result_t exp_res;
        if (!rst_n)
        begin
            gen_words[0] = RNG_INIT0;
            gen_words[1] = RNG_INIT1;
            gen_words[2] = RNG_INIT2;
            gen_words[3] = RNG_INIT3;
            expected_results.delete();
            mismatches = 0;
            fail_count    <= 0;
            pending_count <= 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("value: no item expected, actual %h (error %b)",
                           rsp.value, rsp.error);
                    mismatches++;
                end
                else
                begin
                    exp_res = expected_results.pop_front();
                    if (rsp.value !== exp_res.value)
                    begin
                        $error("value: expected %h, actual %h", exp_res.value, rsp.value);
                        mismatches++;
                    end
                    if (rsp.error !== exp_res.error)
                    begin
                        $error("error: expected %b, actual %b", exp_res.error, rsp.error);
                        mismatches++;
                    end
                end
            end
            if (req.valid && req.ready)
            begin
                expected_results.push_back(predict_rng_result(action_t'(req.action),
                                                              req.operand));
            end
            fail_count    <= mismatches;
            pending_count <= expected_results.size();
        end
    end

endmodule

`default_nettype wire

/* tb/xoshiro256ss_ranged_rng_core_tb.sv */
// top of the ranged xoshiro256** core testbench: clock, reset, request items and verdict
// depends on xrr_pkg, xrr_if, the core and xoshiro256ss_ranged_rng_core_checker
`default_nettype none

module xoshiro256ss_ranged_rng_core_tb import xrr_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEMS_PER_PHASE = 333;
    localparam int DRAIN_CYCLES    = 200;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending_count;
    int   send_idle_pct;
    int   recv_stall_pct;

    xrr_req_if req_ch ();
    xrr_rsp_if rsp_ch ();

    xoshiro256ss_ranged_rng_core u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    xoshiro256ss_ranged_rng_core_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .req           (req_ch),
        .rsp           (rsp_ch),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // hard limit on run length
    initial
    begin
        #10_000_000;
        $display("xoshiro256ss_ranged_rng_core: mismatch");
        $finish;
    end

    // result receiver with random stalls
    initial
    begin
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // present one request item, with optional idle cycles first, until accepted
    task automatic push_item(input action_t act, input logic [63:0] opd);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.action  <= act;
        req_ch.operand <= opd;
        do
        begin
            @(posedge clk);
        end
        while (!req_ch.ready);
    endtask

    // hold off until every expected result item has come back
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (pending_count != 0);
    endtask

    // random request item: seed, integer, fraction or none; integer bounds mostly valid, of every size
    task automatic push_random_item();
        int          pick;
        int          k;
        logic [63:0] opd;
        pick = $urandom_range(0, 99);
        if (pick < 12)
        begin
            push_item(ACT_SEED, rand64());
        end
        else if (pick < 60)
        begin
            k = $urandom_range(1, 63);
            if ($urandom_range(0, 9) == 0)
            begin
                opd = 64'd1 << (k - 1);
            end
            else
            begin
                opd = (rand64() & ((64'd1 << k) - 64'd1)) | (64'd1 << (k - 1));
            end
            push_item(ACT_INT, opd);
        end
        else if (pick < 65)
        begin
            // bad bound: zero or negative
            if ($urandom_range(0, 3) == 0)
            begin
                push_item(ACT_INT, 64'd0);
            end
            else
            begin
                push_item(ACT_INT, rand64() | (64'd1 << 63));
            end
        end
        else if (pick < 94)
        begin
            push_item(ACT_FRAC, rand64());
        end
        else
        begin
            push_item(ACT_NONE, rand64());
        end
    endtask

    // stimulus
    initial
    begin
        rst_n          <= 1'b0;
        req_ch.valid   <= 1'b0;
        req_ch.action  <= ACT_SEED;
        req_ch.operand <= '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: draws from the reset state first
        push_item(ACT_INT, 64'd1);
        push_item(ACT_INT, 64'd2);
        push_item(ACT_INT, 64'd3);
        push_item(ACT_INT, 64'd0);
        push_item(ACT_INT, 64'h8000_0000_0000_0000);
        push_item(ACT_INT, 64'hffff_ffff_ffff_ffff);
        push_item(ACT_INT, 64'h7fff_ffff_ffff_ffff);
        push_item(ACT_INT, 64'h4000_0000_0000_0001);
        push_item(ACT_INT, 64'h4000_0000_0000_0000);
        push_item(ACT_FRAC, 64'd0);
        push_item(ACT_FRAC, 64'hffff_ffff_ffff_ffff);
        push_item(ACT_NONE, 64'd0);
        push_item(ACT_NONE, 64'hffff_ffff_ffff_ffff);
        push_item(ACT_SEED, 64'd0);
        push_item(ACT_FRAC, 64'd0);
        push_item(ACT_INT, 64'h5555_5555_5555_5555);
        push_item(ACT_SEED, 64'hffff_ffff_ffff_ffff);
        push_item(ACT_INT, 64'h0000_0000_0000_0007);
        push_item(ACT_SEED, 64'h5555_5555_5555_5555);
        push_item(ACT_INT, 64'h4000_0000_0000_0003);
        push_item(ACT_SEED, 64'haaaa_aaaa_aaaa_aaaa);
        push_item(ACT_FRAC, 64'haaaa_aaaa_aaaa_aaaa);

        // random phases: no idling, sender idle, receiver stalling, both
        for (int phase = 0; phase < 4; phase++)
        begin
            wait_drained();
            case (phase)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 86; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 86; end
                default: begin send_idle_pct = 15; recv_stall_pct = 15; end
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                push_random_item();
            end
        end

        // drain and settle
        wait_drained();
        recv_stall_pct = 0;
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("xoshiro256ss_ranged_rng_core: match");
        end
        else
        begin
            $display("xoshiro256ss_ranged_rng_core: mismatch");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* files.f */
+incdir+rtl
rtl/xrr_pkg.sv
rtl/xrr_if.sv
rtl/xrr_div.sv
rtl/xrr_datapath.sv
rtl/xrr_ctrl.sv
rtl/xoshiro256ss_ranged_rng_core.sv
tb/xoshiro256ss_ranged_rng_core_checker.sv
tb/xoshiro256ss_ranged_rng_core_tb.sv
